### hw/rtl/bft_pkg.sv
// shared types, constants and a helper function for the breadth-first traversal core
package bft_pkg;

   localparam int NODES_DEFAULT = 16;
   localparam int NODES_MAX     = 64;
   localparam int NODES_MAX_W   = $clog2(NODES_MAX);

   localparam int VERTEX_W   = 4;
   localparam int ROW_W      = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   localparam logic KIND_ROW   = 1'b0;
   localparam logic KIND_START = 1'b1;

   typedef struct packed {
      logic load_row;
      logic start;
      logic q_read;
      logic adj_read;
      logic cand_load;
      logic emit_u;
      logic scan_step;
      logic sweep_adv;
      logic emit_sweep;
   } bft_cmd_type;

   typedef struct packed {
      logic start_ok;
      logic queue_busy;
      logic cand_empty;
      logic out_free;
      logic sweep_hit;
      logic sweep_done;
   } bft_sts_type;

   function automatic logic [NODES_MAX_W-1:0] low_index(input logic [NODES_MAX-1:0] bits);
      logic [NODES_MAX_W-1:0] idx;
      idx = '0;
      for (int i = NODES_MAX - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = NODES_MAX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

### hw/rtl/bft_ram.sv
// generic single write port, single read port ram with registered read
module bft_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bft_ctrl.sv
// controller state machine sequencing row loads, queue pops, neighbour scans and the final sweep
module bft_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   input  bft_pkg::bft_sts_type sts,
   output bft_pkg::bft_cmd_type cmd
);
   import bft_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_POP   = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_SCAN  = 3'd5;
   localparam logic [2:0] ST_SWEEP = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_ROW) begin
                  cmd.load_row = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = sts.start_ok ? ST_POP : ST_SWEEP;
               end
            end
         end
         ST_POP: begin
            if (sts.queue_busy) begin
               cmd.q_read = 1'b1;
               state_in   = ST_FETCH;
            end else begin
               state_in = ST_SWEEP;
            end
         end
         ST_FETCH: begin
            cmd.adj_read = 1'b1;
            state_in     = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.cand_load = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_u = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.cand_empty) begin
               state_in = ST_POP;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_SWEEP: begin
            if (!sts.sweep_hit || sts.out_free) begin
               cmd.sweep_adv  = 1'b1;
               cmd.emit_sweep = sts.sweep_hit;
               if (sts.sweep_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/bft_dp.sv
// datapath: adjacency store, visit queue, visited flags, neighbour encoder and result register
module bft_dp #(
   parameter int NODES = bft_pkg::NODES_DEFAULT,
   localparam int VW = $clog2(NODES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bft_pkg::bft_cmd_type          cmd,
   output bft_pkg::bft_sts_type          sts,
   input  logic [bft_pkg::VERTEX_W-1:0]  req_row_index,
   input  logic [bft_pkg::ROW_W-1:0]     req_row_bits,
   input  logic [bft_pkg::VERTEX_W-1:0]  req_start_vertex,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [bft_pkg::VERTEX_W-1:0]  rsp_vertex,
   output logic                          rsp_last
);
   import bft_pkg::*;

   logic [NODES-1:0]    visited_ff;
   logic [NODES-1:0]    row_valid_ff;
   logic [NODES-1:0]    cand_ff;
   logic [VW:0]         head_ff;
   logic [VW:0]         tail_ff;
   logic [VW-1:0]       u_ff;
   logic [VW-1:0]       sweep_ff;
   logic [VW-1:0]       cnt_ff;
   logic                adj_ok_ff;
   logic                rsp_valid_ff;
   logic [VERTEX_W-1:0] rsp_vertex_ff;
   logic                rsp_last_ff;

   logic             start_ok;
   logic             row_ok;
   logic             out_free;
   logic [VW-1:0]    start_idx;
   logic [VW-1:0]    row_idx;
   logic [VW-1:0]    next_vertex;
   logic [NODES-1:0] low_bit;
   logic             q_we;
   logic [VW-1:0]    q_waddr;
   logic [VW-1:0]    q_wdata;
   logic [VW-1:0]    q_rdata;
   logic [NODES-1:0] adj_rdata;
   logic             emit;

   assign start_ok    = (32'(req_start_vertex) < NODES);
   assign row_ok      = (32'(req_row_index) < NODES);
   assign start_idx   = VW'(req_start_vertex);
   assign row_idx     = VW'(req_row_index);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign next_vertex = VW'(low_index(NODES_MAX'(cand_ff)));
   assign low_bit     = cand_ff & ~(cand_ff - NODES'(1));
   assign emit        = cmd.emit_u || cmd.emit_sweep;

   assign q_we    = (cmd.start && start_ok) || cmd.scan_step;
   assign q_waddr = cmd.start ? '0 : tail_ff[VW-1:0];
   assign q_wdata = cmd.start ? start_idx : next_vertex;

   bft_ram #(
      .WIDTH (VW),
      .DEPTH (NODES)
   ) u_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (head_ff[VW-1:0]),
      .rd_data (q_rdata)
   );

   bft_ram #(
      .WIDTH (NODES),
      .DEPTH (NODES)
   ) u_adj (
      .clock   (clock),
      .wr_en   (cmd.load_row && row_ok),
      .wr_addr (row_idx),
      .wr_data (NODES'(req_row_bits)),
      .rd_addr (q_rdata),
      .rd_data (adj_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff   <= '0;
         row_valid_ff <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         sweep_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_row && row_ok) begin
            row_valid_ff[row_idx] <= 1'b1;
         end
         if (cmd.start) begin
            visited_ff <= start_ok ? (NODES'(1) << start_idx) : '0;
            head_ff    <= '0;
            tail_ff    <= start_ok ? (VW+1)'(1) : '0;
            sweep_ff   <= '0;
            cnt_ff     <= '0;
         end
         if (cmd.q_read) begin
            head_ff <= head_ff + (VW+1)'(1);
         end
         if (cmd.scan_step) begin
            visited_ff <= visited_ff | low_bit;
            tail_ff    <= tail_ff + (VW+1)'(1);
         end
         if (cmd.sweep_adv) begin
            sweep_ff <= sweep_ff + VW'(1);
         end
         if (emit) begin
            cnt_ff       <= cnt_ff + VW'(1);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      adj_ok_ff <= row_valid_ff[q_rdata];
      if (cmd.adj_read) begin
         u_ff <= q_rdata;
      end
      if (cmd.cand_load) begin
         cand_ff <= (adj_ok_ff ? adj_rdata : '0) & ~visited_ff;
      end
      if (cmd.scan_step) begin
         cand_ff <= cand_ff & (cand_ff - NODES'(1));
      end
      if (emit) begin
         rsp_vertex_ff <= cmd.emit_u ? VERTEX_W'(u_ff) : VERTEX_W'(sweep_ff);
         rsp_last_ff   <= (cnt_ff == VW'(NODES - 1));
      end
   end

   assign sts.start_ok   = start_ok;
   assign sts.queue_busy = (head_ff != tail_ff);
   assign sts.cand_empty = (cand_ff == '0);
   assign sts.out_free   = out_free;
   assign sts.sweep_hit  = !visited_ff[sweep_ff];
   assign sts.sweep_done = (sweep_ff == VW'(NODES - 1));

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

### hw/rtl/breadth_first_traversal_core.sv
// breadth-first traversal over an adjacency matrix of row bitmasks
//
// req channel: one transfer either loads one adjacency row (tuser 0) or starts a traversal
// (tuser 1) from start_vertex. a row load gives no result; rows at or above NODES are
// ignored and row bits at or above NODES are dropped.
// rsp channel: exactly NODES transfers follow each start, vertices in visit order and then
// every unvisited vertex in ascending order; tlast marks the final one.
// each vertex popped from the queue passes through a queue read, an adjacency read, a
// candidate load and an emit step, then a scan in which the priority encoder enqueues one
// newly found neighbour per cycle before the scan is left; the closing sweep checks one
// vertex per cycle unless an unvisited vertex waits for a busy output register.
// req_tready is high only between traversals; a new start is taken while the last result
// still waits in the output register.
// reset clears the adjacency rows (per-row valid flags), the queue pointers and the output
// valid flag. when the receiver stalls, the result is held and the traversal waits before its
// next emission.
module breadth_first_traversal_core #(
   parameter int NODES = bft_pkg::NODES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // row_index [3:0], row_bits [19:4], start_vertex [23:20]
   input  logic [bft_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // vertex [3:0], zero padding [7:4]
   output logic [bft_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import bft_pkg::*;

   bft_cmd_type         cmd;
   bft_sts_type         sts;
   logic [VERTEX_W-1:0] rsp_vertex;

   bft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bft_dp #(
      .NODES (NODES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_row_index    (req_tdata[VERTEX_W-1:0]),
      .req_row_bits     (req_tdata[VERTEX_W+ROW_W-1:VERTEX_W]),
      .req_start_vertex (req_tdata[REQ_DATA_W-1:VERTEX_W+ROW_W]),
      .rsp_ready        (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_vertex       (rsp_vertex),
      .rsp_last         (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_vertex);

endmodule

### hw/rtl/bft_checker.sv
// port-level checks for the breadth-first traversal core, bound to the top level
module bft_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bft_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);
   import bft_pkg::*;

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result transfer changed");

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_START |=> !req_tready)
      else $error("new request taken right after a start");

   a_row_ready : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_ROW |=> req_tready)
      else $error("row load left the core busy");

   a_pad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:VERTEX_W] == '0)
      else $error("result padding bits not zero");

endmodule

bind breadth_first_traversal_core bft_checker u_bft_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
